>>> design/trajectory_match_cost_assert.svh
// ----------------------------------------------------------------------------
// Trajectory match cost - assertion macros
// Shared property shapes for the checker of the trajectory match cost block.
// ----------------------------------------------------------------------------
`ifndef TRAJECTORY_MATCH_COST_ASSERT_SVH
`define TRAJECTORY_MATCH_COST_ASSERT_SVH

// same-cycle implication, held off during reset
`define TMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("trajectory_match_cost: assertion failed");

// next-cycle implication, held off during reset
`define TMC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("trajectory_match_cost: assertion failed");

`endif

>>> design/tmc_pkg.sv
// ----------------------------------------------------------------------------
// Trajectory match cost - package
// Widths, limits and register indexes shared by the block and its checker.
// ----------------------------------------------------------------------------
package tmc_pkg;

  // accumulator and output cost width (Q40.8)
  localparam int unsigned CostW = 48;
  localparam logic [CostW-1:0] ACC_MAX = {CostW{1'b1}};

  // yaw wrap limits, 1/64 degree units
  localparam logic [15:0] YAW_FULL   = 16'd23040;
  localparam logic [15:0] YAW_DOUBLE = 16'd46080;
  localparam logic [14:0] YAW_HALF   = 15'd11520;

  // configuration registers
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_POS_WEIGHT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROT_WEIGHT = 2'd1;
  localparam logic [15:0] WEIGHT_RESET = 16'd256;

endpackage

>>> design/trajectory_match_cost.sv
// ----------------------------------------------------------------------------
// Trajectory match cost
// Weighted squared-distance cost accumulator over pairs of trajectory points,
// built around one shared 26x24 multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  in_       input      in_valid / in_stall     cur/cand x,y,z,yaw, last_point
//  out_      output     out_valid / out_stall   total_cost, saturated
//  cfg_      input      cfg_we                  cfg_index, cfg_wdata
//
//  Each request is accepted in the idle state, then runs nine sequencer steps
//  (three squares, the last square-sum add, two weight partial products,
//  one yaw product, two adds), all set by the single shared multiplier and its
//  result register. in_stall is high while the sequencer runs.
//  A last point waits in the final step only while the output register holds
//  an untaken result; otherwise out_stall does not hold up the input side.
//  Reset (rst_n low, synchronous) clears the cost, the flag and the output,
//  and sets both weights to 1.0.
//
module trajectory_match_cost (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_we,
  input  logic [tmc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [15:0]                  cfg_wdata,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [23:0]           in_cur_x,
  input  logic signed [23:0]           in_cur_y,
  input  logic signed [23:0]           in_cur_z,
  input  logic signed [15:0]           in_cur_yaw,
  input  logic signed [23:0]           in_cand_x,
  input  logic signed [23:0]           in_cand_y,
  input  logic signed [23:0]           in_cand_z,
  input  logic signed [15:0]           in_cand_yaw,
  input  logic                         in_last_point,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tmc_pkg::CostW-1:0]    out_total_cost,
  output logic                         out_saturated
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SQZ,
    ST_SUMZ,
    ST_WLO,
    ST_WHI,
    ST_ROT,
    ST_POS,
    ST_DONE
  } state_t;

  state_t                      state_r;
  logic [15:0]                 pos_weight_r;
  logic [15:0]                 rot_weight_r;
  logic [tmc_pkg::CostW-1:0]   acc_r;
  logic                        sat_flag_r;
  logic                        out_valid_r;
  logic [tmc_pkg::CostW-1:0]   out_total_r;
  logic                        out_sat_r;

  // payload registers
  logic [23:0]                 mag_x_r, mag_y_r, mag_z_r;
  logic [13:0]                 yaw_mag_r;
  logic                        last_r;
  logic [49:0]                 mul_r;
  logic [49:0]                 sqsum_r;
  logic [25:0]                 lo_r;
  logic [49:0]                 pos_r;
  logic [50:0]                 sum_r;
  logic [23:0]                 rot_r;

  logic                        accept;
  logic                        out_free;
  logic                        emit;

  // input differences and magnitudes
  logic signed [24:0]          dx, dy, dz;
  logic [23:0]                 mag_x, mag_y, mag_z;
  logic signed [16:0]          dyaw;
  logic [15:0]                 yaw_abs;
  logic [14:0]                 yaw_mod;
  logic [13:0]                 yaw_mag;

  // shared multiplier
  logic [25:0]                 mul_a;
  logic [23:0]                 mul_b;
  logic [49:0]                 mul_nxt;

  // final add and saturation
  logic [50:0]                 total;
  logic                        sat_hit;
  logic [tmc_pkg::CostW-1:0]   acc_nxt;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign emit     = (state_r == ST_DONE) && last_r && out_free;

  // position differences, exact in 25 bits
  always_comb begin
    dx = 25'(in_cand_x) - 25'(in_cur_x);
    dy = 25'(in_cand_y) - 25'(in_cur_y);
    dz = 25'(in_cand_z) - 25'(in_cur_z);
    mag_x = dx[24] ? 24'(-dx) : dx[23:0];
    mag_y = dy[24] ? 24'(-dy) : dy[23:0];
    mag_z = dz[24] ? 24'(-dz) : dz[23:0];
  end

  // yaw difference: magnitude folded into [0, 180] degrees
  always_comb begin
    dyaw    = 17'(in_cand_yaw) - 17'(in_cur_yaw);
    yaw_abs = dyaw[16] ? 16'(-dyaw) : dyaw[15:0];
    if (yaw_abs >= tmc_pkg::YAW_DOUBLE) begin
      yaw_mod = 15'(yaw_abs - tmc_pkg::YAW_DOUBLE);
    end else if (yaw_abs >= tmc_pkg::YAW_FULL) begin
      yaw_mod = 15'(yaw_abs - tmc_pkg::YAW_FULL);
    end else begin
      yaw_mod = yaw_abs[14:0];
    end
    if (yaw_mod > tmc_pkg::YAW_HALF) begin
      yaw_mag = 14'(tmc_pkg::YAW_FULL[14:0] - yaw_mod);
    end else begin
      yaw_mag = yaw_mod[13:0];
    end
  end

  // multiplier operand select per sequencer step
  always_comb begin
    case (state_r)
      ST_SQX: begin
        mul_a = {2'b00, mag_x_r};
        mul_b = mag_x_r;
      end
      ST_SQY: begin
        mul_a = {2'b00, mag_y_r};
        mul_b = mag_y_r;
      end
      ST_SQZ: begin
        mul_a = {2'b00, mag_z_r};
        mul_b = mag_z_r;
      end
      ST_WLO: begin
        mul_a = sqsum_r[25:0];
        mul_b = {8'd0, pos_weight_r};
      end
      ST_WHI: begin
        mul_a = {2'b00, sqsum_r[49:26]};
        mul_b = {8'd0, pos_weight_r};
      end
      ST_ROT: begin
        mul_a = {12'd0, yaw_mag_r};
        mul_b = {8'd0, rot_weight_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_nxt = {24'd0, mul_a} * {26'd0, mul_b};
  end

  // final add with saturation at the accumulator maximum
  always_comb begin
    total   = sum_r + {27'd0, rot_r};
    sat_hit = (total >= {3'b000, tmc_pkg::ACC_MAX});
    acc_nxt = sat_hit ? tmc_pkg::ACC_MAX : total[tmc_pkg::CostW-1:0];
  end

  // sequencer, accumulator, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pos_weight_r <= tmc_pkg::WEIGHT_RESET;
      rot_weight_r <= tmc_pkg::WEIGHT_RESET;
      acc_r        <= '0;
      sat_flag_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tmc_pkg::CFG_POS_WEIGHT: pos_weight_r <= cfg_wdata;
          tmc_pkg::CFG_ROT_WEIGHT: rot_weight_r <= cfg_wdata;
          default: ;
        endcase
      end

      // result register: set on emission, held while stalled
      out_valid_r <= emit || (out_valid_r && out_stall);

      case (state_r)
        ST_IDLE: if (accept) state_r <= ST_SQX;
        ST_SQX:  state_r <= ST_SQY;
        ST_SQY:  state_r <= ST_SQZ;
        ST_SQZ:  state_r <= ST_SUMZ;
        ST_SUMZ: state_r <= ST_WLO;
        ST_WLO:  state_r <= ST_WHI;
        ST_WHI:  state_r <= ST_ROT;
        ST_ROT:  state_r <= ST_POS;
        ST_POS:  state_r <= ST_DONE;
        ST_DONE: begin
          if (!last_r) begin
            acc_r      <= acc_nxt;
            sat_flag_r <= sat_flag_r | sat_hit;
            state_r    <= ST_IDLE;
          end else if (out_free) begin
            // last point: emit and clear the run
            out_total_r <= acc_nxt;
            out_sat_r   <= sat_flag_r | sat_hit;
            acc_r       <= '0;
            sat_flag_r  <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    mul_r <= mul_nxt;
    if (accept) begin
      mag_x_r   <= mag_x;
      mag_y_r   <= mag_y;
      mag_z_r   <= mag_z;
      yaw_mag_r <= yaw_mag;
      last_r    <= in_last_point;
      sqsum_r   <= '0;
    end
    case (state_r)
      ST_SQY, ST_SQZ, ST_SUMZ: sqsum_r <= sqsum_r + mul_r;
      // low partial product, keep only bits at or above the Q.16 point
      ST_WHI: lo_r <= mul_r[41:16];
      ST_ROT: pos_r <= {mul_r[39:0], 10'd0} + {24'd0, lo_r};
      ST_POS: begin
        sum_r <= {3'b000, acc_r} + {1'b0, pos_r};
        rot_r <= mul_r[29:6];
      end
      default: ;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_total_cost = out_total_r;
  assign out_saturated  = out_sat_r;

endmodule

>>> design/tmc_checker.sv
// ----------------------------------------------------------------------------
// Trajectory match cost - port checker
// Watches the ports of the trajectory match cost block over time.
// ----------------------------------------------------------------------------
`include "trajectory_match_cost_assert.svh"

module tmc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [tmc_pkg::CostW-1:0]  out_total_cost,
  input logic                       out_saturated
);

  // a stalled result holds
  `TMC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_total_cost) && $stable(out_saturated))

  // a saturated run always reports the maximum cost
  `TMC_ASSERT_IMP(a_sat_max, clk, rst_n, out_valid && out_saturated, out_total_cost == tmc_pkg::ACC_MAX)

  // the sequencer is busy right after a request is taken
  `TMC_ASSERT_NXT(a_busy_after_req, clk, rst_n, in_valid && !in_stall, in_stall)

  // no result can appear in the cycle after a request is taken
  `TMC_ASSERT_NXT(a_no_early_out, clk, rst_n, in_valid && !in_stall, !$rose(out_valid))

endmodule

bind trajectory_match_cost tmc_checker u_tmc_checker (.*);

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Trajectory match cost - testbench
// Drives pairs of trajectory points into the cost accumulator and checks every
// emitted total against a cycle-free prediction of the weighted cost, across
// several weight settings and with random idling on both channels.
// ----------------------------------------------------------------------------

// one request: current and candidate pose, plus end-of-trajectory marker
typedef struct {
  logic signed [23:0] cur_x;
  logic signed [23:0] cur_y;
  logic signed [23:0] cur_z;
  logic signed [15:0] cur_yaw;
  logic signed [23:0] cand_x;
  logic signed [23:0] cand_y;
  logic signed [23:0] cand_z;
  logic signed [15:0] cand_yaw;
  logic               last;
} point_pair_t;

// one emitted total
typedef struct {
  logic [tmc_pkg::CostW-1:0] cost;
  logic                      sat;
} cost_total_t;

// Running cost prediction and the queue of totals still owed by the block
class trajectory_cost_board;
  localparam int YAW_TURN      = int'(tmc_pkg::YAW_FULL);
  localparam int YAW_HALF_TURN = int'(tmc_pkg::YAW_HALF);

  logic [15:0]               pos_weight;
  logic [15:0]               rot_weight;
  logic [tmc_pkg::CostW-1:0] cost_acc;
  logic                      sat_flag;
  cost_total_t               pending_totals[$];
  int                        mismatches;

  function new();
    pos_weight = tmc_pkg::WEIGHT_RESET;
    rot_weight = tmc_pkg::WEIGHT_RESET;
    cost_acc   = '0;
    sat_flag   = 1'b0;
    mismatches = 0;
  endfunction

  function int pending();
    return pending_totals.size();
  endfunction

  task report(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // unknown indexes are dropped by the block
  function void apply_write(input logic [tmc_pkg::CfgIdxW-1:0] idx,
                            input logic [15:0] val);
    case (idx)
      tmc_pkg::CFG_POS_WEIGHT: pos_weight = val;
      tmc_pkg::CFG_ROT_WEIGHT: rot_weight = val;
      default: ;
    endcase
  endfunction

  // add one point pair to the running cost, queue the total on a last point
  function void add_point_pair(input point_pair_t p);
    longint      dx, dy, dz;
    logic [79:0] dist_sq, pos_term, total;
    int          yaw_d, yaw_r;
    longint unsigned rot_term;
    dx = longint'(p.cand_x) - longint'(p.cur_x);
    dy = longint'(p.cand_y) - longint'(p.cur_y);
    dz = longint'(p.cand_z) - longint'(p.cur_z);
    dist_sq  = 80'(dx * dx + dy * dy + dz * dz);
    pos_term = (dist_sq * pos_weight) >> 16;
    // yaw difference folded into half a turn either way, truncating remainder
    yaw_d = int'(p.cand_yaw) - int'(p.cur_yaw);
    yaw_r = yaw_d % YAW_TURN;
    if (yaw_r > YAW_HALF_TURN) begin
      yaw_r -= YAW_TURN;
    end else if (yaw_r < -YAW_HALF_TURN) begin
      yaw_r += YAW_TURN;
    end
    if (yaw_r < 0) begin
      yaw_r = -yaw_r;
    end
    rot_term = (longint'(yaw_r) * rot_weight) >> 6;
    total = 80'(cost_acc) + pos_term + 80'(rot_term);
    if (total >= 80'(tmc_pkg::ACC_MAX)) begin
      cost_acc = tmc_pkg::ACC_MAX;
      sat_flag = 1'b1;
    end else begin
      cost_acc = total[tmc_pkg::CostW-1:0];
    end
    if (p.last) begin
      pending_totals.push_back('{cost_acc, sat_flag});
      cost_acc = '0;
      sat_flag = 1'b0;
    end
  endfunction

  task check_total(input logic [tmc_pkg::CostW-1:0] cost, input logic sat);
    cost_total_t want;
    if (pending_totals.size() == 0) begin
      report($sformatf("total %0h arrived with none owed", cost));
      return;
    end
    want = pending_totals.pop_front();
    if (cost !== want.cost) begin
      report($sformatf("total_cost %0h, want %0h", cost, want.cost));
    end
    if (sat !== want.sat) begin
      report($sformatf("saturated %0b, want %0b", sat, want.sat));
    end
  endtask
endclass

module tb;

  localparam logic [tmc_pkg::CfgIdxW-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [tmc_pkg::CfgIdxW-1:0] CFG_SPARE_HI = 2'd3;
  localparam logic signed [23:0] POS_MIN = 24'sh800000;
  localparam logic signed [23:0] POS_MAX = 24'sh7fffff;
  localparam logic signed [15:0] YAW_MIN = 16'sh8000;
  localparam logic signed [15:0] YAW_MAX = 16'sh7fff;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 84;
  localparam int SETTLE      = 24;
  localparam int QUIET_LIMIT = 5000;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_we;
  logic [tmc_pkg::CfgIdxW-1:0] cfg_index;
  logic [15:0]                 cfg_wdata;
  logic                        in_valid;
  logic                        in_stall;
  logic signed [23:0]          in_cur_x, in_cur_y, in_cur_z;
  logic signed [15:0]          in_cur_yaw;
  logic signed [23:0]          in_cand_x, in_cand_y, in_cand_z;
  logic signed [15:0]          in_cand_yaw;
  logic                        in_last_point;
  logic                        out_valid;
  logic                        out_stall;
  logic [tmc_pkg::CostW-1:0]   out_total_cost;
  logic                        out_saturated;

  trajectory_cost_board sb;
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles = 0;

  trajectory_match_cost dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cur_x       (in_cur_x),
    .in_cur_y       (in_cur_y),
    .in_cur_z       (in_cur_z),
    .in_cur_yaw     (in_cur_yaw),
    .in_cand_x      (in_cand_x),
    .in_cand_y      (in_cand_y),
    .in_cand_z      (in_cand_z),
    .in_cand_yaw    (in_cand_yaw),
    .in_last_point  (in_last_point),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_total_cost (out_total_cost),
    .out_saturated  (out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver back-pressure, changed on the falling edge
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = rst_n && ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result check first, then note the request taken at the same edge
  always @(posedge clk) begin
    point_pair_t req;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_total(out_total_cost, out_saturated);
      end
      if (in_valid && !in_stall) begin
        req.cur_x    = in_cur_x;
        req.cur_y    = in_cur_y;
        req.cur_z    = in_cur_z;
        req.cur_yaw  = in_cur_yaw;
        req.cand_x   = in_cand_x;
        req.cand_y   = in_cand_y;
        req.cand_z   = in_cand_z;
        req.cand_yaw = in_cand_yaw;
        req.last     = in_last_point;
        sb.add_point_pair(req);
      end
    end
  end

  // watchdog: too long with no request moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("trajectory_match_cost test failed");
      $finish;
    end
  end

  function automatic point_pair_t mk_pair(
    input logic signed [23:0] cx, cy, cz, input logic signed [15:0] cyaw,
    input logic signed [23:0] ax, ay, az, input logic signed [15:0] ayaw,
    input logic last);
    point_pair_t p;
    p.cur_x  = cx; p.cur_y  = cy; p.cur_z  = cz; p.cur_yaw  = cyaw;
    p.cand_x = ax; p.cand_y = ay; p.cand_z = az; p.cand_yaw = ayaw;
    p.last   = last;
    return p;
  endfunction

  function automatic logic signed [23:0] corner_pos();
    case ($urandom_range(3))
      0: return POS_MIN;
      1: return POS_MAX;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic signed [15:0] corner_yaw();
    case ($urandom_range(3))
      0: return YAW_MIN;
      1: return YAW_MAX;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  // mostly nearby points, some fully random, a few at the corners
  function automatic point_pair_t random_pair(input logic last);
    point_pair_t p;
    int          kind, bx, by, bz;
    kind = $urandom_range(99);
    p.last = last;
    if (kind < 65) begin
      bx = int'($urandom_range(0, 8388607)) - 4194304;
      by = int'($urandom_range(0, 8388607)) - 4194304;
      bz = int'($urandom_range(0, 8388607)) - 4194304;
      p.cur_x    = 24'(bx);
      p.cur_y    = 24'(by);
      p.cur_z    = 24'(bz);
      p.cand_x   = 24'(bx + int'($urandom_range(0, 8192)) - 4096);
      p.cand_y   = 24'(by + int'($urandom_range(0, 8192)) - 4096);
      p.cand_z   = 24'(bz + int'($urandom_range(0, 8192)) - 4096);
      p.cur_yaw  = 16'($urandom);
      p.cand_yaw = p.cur_yaw + 16'(int'($urandom_range(0, 2048)) - 1024);
    end else if (kind < 90) begin
      p.cur_x    = 24'($urandom);
      p.cur_y    = 24'($urandom);
      p.cur_z    = 24'($urandom);
      p.cur_yaw  = 16'($urandom);
      p.cand_x   = 24'($urandom);
      p.cand_y   = 24'($urandom);
      p.cand_z   = 24'($urandom);
      p.cand_yaw = 16'($urandom);
    end else begin
      p.cur_x    = corner_pos();
      p.cur_y    = corner_pos();
      p.cur_z    = corner_pos();
      p.cur_yaw  = corner_yaw();
      p.cand_x   = corner_pos();
      p.cand_y   = corner_pos();
      p.cand_z   = corner_pos();
      p.cand_yaw = corner_yaw();
    end
    return p;
  endfunction

  // present one request from the falling edge, hold until taken
  task automatic send_pair(input point_pair_t p);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_cur_x      = p.cur_x;
    in_cur_y      = p.cur_y;
    in_cur_z      = p.cur_z;
    in_cur_yaw    = p.cur_yaw;
    in_cand_x     = p.cand_x;
    in_cand_y     = p.cand_y;
    in_cand_z     = p.cand_z;
    in_cand_yaw   = p.cand_yaw;
    in_last_point = p.last;
    in_valid      = 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending and wait for every owed total; optionally let the block go idle
  task automatic drain(input bit settle);
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    if (settle) begin
      repeat (SETTLE) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [tmc_pkg::CfgIdxW-1:0] idx,
                           input logic [15:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    sb.apply_write(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    int left, run_len;
    sb = new();
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_cur_x      = '0; in_cur_y  = '0; in_cur_z  = '0; in_cur_yaw  = '0;
    in_cand_x     = '0; in_cand_y = '0; in_cand_z = '0; in_cand_yaw = '0;
    in_last_point = 1'b0;
    send_idle_pct = 37;
    recv_idle_pct = 52;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, reset weights: zero cost, truncation, position extremes
    send_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    send_pair(mk_pair(0, 0, 0, 0, 1, 0, 0, 1, 1'b1));
    send_pair(mk_pair(POS_MIN, POS_MAX, POS_MIN, YAW_MIN,
                      POS_MAX, POS_MIN, POS_MAX, YAW_MAX, 1'b0));
    send_pair(mk_pair(POS_MAX, POS_MIN, POS_MAX, YAW_MAX,
                      POS_MIN, POS_MAX, POS_MIN, YAW_MIN, 1'b1));
    // yaw wrap: half turn each way, full turn, just past half, one and a half
    send_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 11520, 1'b0));
    send_pair(mk_pair(0, 0, 0, 11520, 0, 0, 0, 0, 1'b0));
    send_pair(mk_pair(0, 0, 0, -11520, 0, 0, 0, 11520, 1'b0));
    send_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 11521, 1'b0));
    send_pair(mk_pair(0, 0, 0, 11521, 0, 0, 0, 0, 1'b0));
    send_pair(mk_pair(0, 0, 0, -17280, 0, 0, 0, 17280, 1'b1));
    send_pair(mk_pair(0, 0, 0, 17281, 0, 0, 0, -17280, 1'b1));
    drain(1'b1);

    // full weights: one corner pair saturates, the flag clears after emission
    write_reg(tmc_pkg::CFG_POS_WEIGHT, 16'hffff);
    write_reg(tmc_pkg::CFG_ROT_WEIGHT, 16'hffff);
    send_pair(mk_pair(POS_MIN, POS_MIN, POS_MIN, YAW_MIN,
                      POS_MAX, POS_MAX, POS_MAX, YAW_MAX, 1'b0));
    send_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    send_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    drain(1'b1);

    // zero weights, and writes to unused indexes that must change nothing
    write_reg(tmc_pkg::CFG_POS_WEIGHT, 16'h0000);
    write_reg(tmc_pkg::CFG_ROT_WEIGHT, 16'h0000);
    write_reg(CFG_SPARE_LO, 16'hffff);
    write_reg(CFG_SPARE_HI, 16'h5a5a);
    send_pair(mk_pair(POS_MIN, POS_MAX, POS_MIN, YAW_MIN,
                      POS_MAX, POS_MIN, POS_MAX, 11520, 1'b1));

    // random phases, each under its own weights
    for (int phase = 0; phase < PHASES; phase++) begin
      drain(1'b1);
      case (phase / 2)
        0: begin send_idle_pct = 37; recv_idle_pct = 52; end
        1: begin send_idle_pct = 52; recv_idle_pct = 37; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (phase)
        0: begin
          write_reg(tmc_pkg::CFG_POS_WEIGHT, 16'hffff);
          write_reg(tmc_pkg::CFG_ROT_WEIGHT, 16'h0000);
        end
        1: begin
          write_reg(tmc_pkg::CFG_POS_WEIGHT, 16'h0000);
          write_reg(tmc_pkg::CFG_ROT_WEIGHT, 16'hffff);
        end
        3: begin
          write_reg(tmc_pkg::CFG_POS_WEIGHT, 16'hffff);
          write_reg(tmc_pkg::CFG_ROT_WEIGHT, 16'hffff);
        end
        4: begin
          write_reg(tmc_pkg::CFG_POS_WEIGHT, 16'h0001);
          write_reg(tmc_pkg::CFG_ROT_WEIGHT, 16'h0001);
        end
        default: begin
          write_reg(tmc_pkg::CFG_POS_WEIGHT, 16'($urandom));
          write_reg(tmc_pkg::CFG_ROT_WEIGHT, 16'($urandom));
        end
      endcase
      write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, 16'($urandom));

      // trajectories of random length; now and then a long one
      left = PHASE_ITEMS;
      while (left > 0) begin
        run_len = ($urandom_range(19) == 0) ? $urandom_range(15, 40)
                                             : $urandom_range(1, 6);
        if (run_len > left) begin
          run_len = left;
        end
        // occasional hold-off until every owed total is out
        if ($urandom_range(24) == 0) begin
          drain(1'b0);
        end
        for (int i = 0; i < run_len; i++) begin
          send_pair(random_pair(i == run_len - 1));
        end
        left -= run_len;
      end
    end

    drain(1'b0);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("trajectory_match_cost test passed");
    end else begin
      $display("trajectory_match_cost test failed");
    end
    $finish;
  end

endmodule
